### hdl/pcft_pkg.sv
// ----------------------------------------------------------------------------
// pcft_pkg
// Shared types and constants for the pump current fault trip block.
// ----------------------------------------------------------------------------
package pcft_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned MA_W        = 16;
  localparam int unsigned MS_W        = 32;
  localparam int unsigned DUR_S_W     = 16;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned DUR_MS_W    = 26;   // 65535 * 1000 fits in 26 bits
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [DUR_S_W-1:0] DURATION_S_RST = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_PRESENT = 3'd0,
    CFG_CHECK_ENABLED  = 3'd1,
    CFG_BELOW_MODE     = 3'd2,
    CFG_THRESHOLD_MA   = 3'd3,
    CFG_DURATION_S     = 3'd4
  } pcft_cfg_idx_t;

  typedef struct packed {
    logic                      sensor_present;
    logic                      check_enabled;
    logic                      below_mode;
    logic signed [MA_W-1:0]    threshold_ma;
    logic        [DUR_MS_W-1:0] duration_ms;
  } pcft_cfg_t;

  typedef struct packed {
    logic                   pump_active;
    logic signed [MA_W-1:0] current_ma;
    logic        [MS_W-1:0] now_ms;
  } pcft_sample_t;

  typedef struct packed {
    logic                   tank_empty;
    logic                   stop_pump;
    logic                   range_valid;
    logic signed [MA_W-1:0] max_ma;
    logic signed [MA_W-1:0] min_ma;
    logic signed [MA_W-1:0] last_ma;
  } pcft_result_t;

endpackage

### hdl/pcft_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcft_cfg_regs
// Configuration register bank; the persistence time is kept in milliseconds.
// ----------------------------------------------------------------------------
module pcft_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pcft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcft_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pcft_pkg::pcft_cfg_t                 cfg
);
  import pcft_pkg::*;

  pcft_cfg_t cfg_r;
  pcft_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENSOR_PRESENT: cfg_nxt.sensor_present = cfg_data[0];
        CFG_CHECK_ENABLED:  cfg_nxt.check_enabled  = cfg_data[0];
        CFG_BELOW_MODE:     cfg_nxt.below_mode     = cfg_data[0];
        CFG_THRESHOLD_MA:   cfg_nxt.threshold_ma   = $signed(cfg_data[MA_W-1:0]);
        CFG_DURATION_S:     cfg_nxt.duration_ms    =
          DUR_MS_W'(cfg_data[DUR_S_W-1:0]) * DUR_MS_W'(MS_PER_S);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_present <= 1'b1;
      cfg_r.check_enabled  <= 1'b0;
      cfg_r.below_mode     <= 1'b1;
      cfg_r.threshold_ma   <= '0;
      cfg_r.duration_ms    <= DUR_MS_W'(DURATION_S_RST) * DUR_MS_W'(MS_PER_S);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/pcft_eval.sv
// ----------------------------------------------------------------------------
// pcft_eval
// Monitor state and the per-sample evaluation: range tracking, threshold
// compare and persistence timing.
// ----------------------------------------------------------------------------
module pcft_eval (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  pcft_pkg::pcft_sample_t  smp,
  input  pcft_pkg::pcft_cfg_t     cfg,
  output pcft_pkg::pcft_result_t  res
);
  import pcft_pkg::*;

  logic                   was_running_r, was_running_nxt;
  logic                   fault_r, fault_nxt;
  logic                   pending_r, pending_nxt;
  logic        [MS_W-1:0] start_ms_r, start_ms_nxt;
  logic signed [MA_W-1:0] last_r, last_nxt;
  logic                   have_range_r, have_range_nxt;
  logic signed [MA_W-1:0] min_r, min_nxt;
  logic signed [MA_W-1:0] max_r, max_nxt;
  logic                   stop;
  logic                   run_start;
  logic                   met;
  logic        [MS_W-1:0] elapsed;

  assign run_start = smp.pump_active && !was_running_r;
  assign elapsed   = smp.now_ms - start_ms_r;
  assign met       = cfg.below_mode ? (smp.current_ma < cfg.threshold_ma)
                                    : (smp.current_ma > cfg.threshold_ma);

  always_comb begin
    was_running_nxt = was_running_r;
    fault_nxt       = fault_r;
    pending_nxt     = pending_r;
    start_ms_nxt    = start_ms_r;
    last_nxt        = last_r;
    have_range_nxt  = have_range_r;
    min_nxt         = min_r;
    max_nxt         = max_r;
    stop            = 1'b0;
    if (cfg.sensor_present) begin
      was_running_nxt = smp.pump_active;
      if (run_start) begin
        fault_nxt   = 1'b0;
        pending_nxt = 1'b0;
      end
      if (!smp.pump_active) begin
        last_nxt = '0;
      end else begin
        last_nxt       = smp.current_ma;
        have_range_nxt = 1'b1;
        if (!have_range_r || smp.current_ma < min_r) min_nxt = smp.current_ma;
        if (!have_range_r || smp.current_ma > max_r) max_nxt = smp.current_ma;
        if (cfg.check_enabled) begin
          if (!met) begin
            pending_nxt = 1'b0;
          end else if (!pending_nxt) begin
            // first qualifying sample only starts the timer
            pending_nxt  = 1'b1;
            start_ms_nxt = smp.now_ms;
          end else if (elapsed >= MS_W'(cfg.duration_ms)) begin
            fault_nxt   = 1'b1;
            pending_nxt = 1'b0;
            stop        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_running_r <= 1'b0;
      fault_r       <= 1'b0;
      pending_r     <= 1'b0;
      start_ms_r    <= '0;
      last_r        <= '0;
      have_range_r  <= 1'b0;
      min_r         <= '0;
      max_r         <= '0;
    end else if (step) begin
      was_running_r <= was_running_nxt;
      fault_r       <= fault_nxt;
      pending_r     <= pending_nxt;
      start_ms_r    <= start_ms_nxt;
      last_r        <= last_nxt;
      have_range_r  <= have_range_nxt;
      min_r         <= min_nxt;
      max_r         <= max_nxt;
    end
  end

  assign res.last_ma     = last_nxt;
  assign res.min_ma      = min_nxt;
  assign res.max_ma      = max_nxt;
  assign res.range_valid = have_range_nxt;
  assign res.stop_pump   = stop;
  assign res.tank_empty  = fault_nxt;

endmodule

### hdl/pump_current_fault_trip.sv
// ----------------------------------------------------------------------------
// pump_current_fault_trip
// Pipeline: input beat to result beat through the input register and the
// result register. Throughput: one sample per cycle unless out_tready stalls
// the output, bounded by the single-pass compare/subtract path between them.
// Reset (rst_n, synchronous): both stages empty, monitor state cleared,
// configuration back to its defaults.
// ----------------------------------------------------------------------------
module pump_current_fault_trip (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // pump_active[0], current_ma[16:1], now_ms[48:17], zero fill
  input  logic [pcft_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // last_ma[15:0], min_ma[31:16], max_ma[47:32], range_valid[48],
  // stop_pump[49], tank_empty[50], zero fill
  output logic [pcft_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [pcft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcft_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pcft_pkg::*;

  pcft_cfg_t    cfg;
  pcft_sample_t smp_r, smp_nxt;
  logic         in_valid_r, in_valid_nxt;
  pcft_result_t res;
  pcft_result_t res_r;
  logic         out_valid_r, out_valid_nxt;
  logic         advance;
  logic         step;
  logic         in_beat;

  pcft_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcft_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .smp   (smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    smp_nxt = smp_r;
    if (in_beat) begin
      smp_nxt.pump_active = in_tdata[0];
      smp_nxt.current_ma  = $signed(in_tdata[MA_W:1]);
      smp_nxt.now_ms      = in_tdata[MA_W+MS_W:MA_W+1];
    end
    in_valid_nxt  = in_beat ? 1'b1 : (step ? 1'b0 : in_valid_r);
    out_valid_nxt = step ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(pcft_result_t))'(0), res_r};

  // a stop beat always carries the latched fault flag
  a_stop_latches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.stop_pump |-> res_r.tank_empty)
    else $error("stop pulse without tank_empty");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.range_valid |-> res_r.min_ma <= res_r.max_ma)
    else $error("min above max");

  a_range_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.range_valid |=> res_r.range_valid)
    else $error("range_valid dropped");

  // a held sample in the input stage must not move while the output stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(smp_r))
    else $error("input stage lost a sample");

endmodule

### sim/trip_check_pkg.sv
// ----------------------------------------------------------------------------
// trip_check_pkg
// Scoreboard for the pump current fault trip block. It mirrors the register
// file and the monitor state, works out the result beat due for every
// accepted sample, and compares result beats field by field in order.
// ----------------------------------------------------------------------------
package trip_check_pkg;
  import pcft_pkg::*;

  class trip_scoreboard;
    // register mirror
    bit                       sensor_present;
    bit                       check_enabled;
    bit                       below_mode;
    logic signed [MA_W-1:0]   threshold_ma;
    logic        [DUR_S_W-1:0] duration_s;

    // monitor state
    bit                       was_running;
    bit                       fault_latched;
    bit                       pending;
    bit                       have_range;
    logic        [MS_W-1:0]   pending_since_ms;
    logic signed [MA_W-1:0]   last_ma;
    logic signed [MA_W-1:0]   min_ma;
    logic signed [MA_W-1:0]   max_ma;

    pcft_result_t             expected_q[$];
    int unsigned              n_samples;
    int unsigned              n_checked;
    int unsigned              n_trips;
    int unsigned              n_errors;

    function new();
      sensor_present   = 1'b1;
      check_enabled    = 1'b0;
      below_mode       = 1'b1;
      threshold_ma     = '0;
      duration_s       = DURATION_S_RST;
      was_running      = 1'b0;
      fault_latched    = 1'b0;
      pending          = 1'b0;
      have_range       = 1'b0;
      pending_since_ms = '0;
      last_ma          = '0;
      min_ma           = '0;
      max_ma           = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      unique case (idx)
        CFG_SENSOR_PRESENT: sensor_present = data[0];
        CFG_CHECK_ENABLED:  check_enabled  = data[0];
        CFG_BELOW_MODE:     below_mode     = data[0];
        CFG_THRESHOLD_MA:   threshold_ma   = data;
        CFG_DURATION_S:     duration_s     = data;
        default: ;
      endcase
    endfunction

    function void note_sample(pcft_sample_t s);
      pcft_result_t           res;
      logic signed [MA_W-1:0] cur;
      logic        [MS_W-1:0] elapsed;
      logic        [MS_W-1:0] hold_ms;
      bit                     met;
      bit                     tripped;
      tripped = 1'b0;
      cur     = s.current_ma;
      hold_ms = duration_s * MS_PER_S;
      n_samples++;
      // without a sensor nothing moves
      if (sensor_present) begin
        if (s.pump_active && !was_running) begin
          fault_latched = 1'b0;
          pending       = 1'b0;
        end
        was_running = s.pump_active;
        if (!s.pump_active) begin
          last_ma = '0;
        end else begin
          last_ma = cur;
          if (!have_range) begin
            have_range = 1'b1;
            min_ma     = cur;
            max_ma     = cur;
          end else begin
            if (cur < min_ma) min_ma = cur;
            if (cur > max_ma) max_ma = cur;
          end
          if (check_enabled) begin
            met     = below_mode ? (cur < threshold_ma) : (cur > threshold_ma);
            elapsed = s.now_ms - pending_since_ms;
            if (!met) begin
              pending = 1'b0;
            end else if (!pending) begin
              pending          = 1'b1;
              pending_since_ms = s.now_ms;
            end else if (elapsed >= hold_ms) begin
              fault_latched = 1'b1;
              pending       = 1'b0;
              tripped       = 1'b1;
              n_trips++;
            end
          end
        end
      end
      res.last_ma     = last_ma;
      res.min_ma      = min_ma;
      res.max_ma      = max_ma;
      res.range_valid = have_range;
      res.stop_pump   = tripped;
      res.tank_empty  = fault_latched;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, int want, int got, time stamp);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", stamp, field, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, time stamp);
      pcft_result_t got;
      pcft_result_t want;
      got = pcft_result_t'(tdata[$bits(pcft_result_t)-1:0]);
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 stamp, tdata);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      compare_field("last_ma",     want.last_ma,     got.last_ma,     stamp);
      compare_field("min_ma",      want.min_ma,      got.min_ma,      stamp);
      compare_field("max_ma",      want.max_ma,      got.max_ma,      stamp);
      compare_field("range_valid", want.range_valid, got.range_valid, stamp);
      compare_field("stop_pump",   want.stop_pump,   got.stop_pump,   stamp);
      compare_field("tank_empty",  want.tank_empty,  got.tank_empty,  stamp);
    endfunction
  endclass

endpackage

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for pump_current_fault_trip. A directed opening covers the
// current extremes, run start and stop, both trip directions, zero and
// longest hold times, timestamp wrap, disabled checking and an absent sensor;
// random phases then follow with fresh register settings and samples biased
// towards the trip side. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcft_pkg::*;
  import trip_check_pkg::*;

  localparam int unsigned DUT_LATENCY    = 2;
  localparam int unsigned IDLE_LIMIT     = 1000;
  localparam int unsigned GAP_MAX        = 11;
  localparam int unsigned RANDOM_SAMPLES = 800;
  localparam int          MA_HI          = 32767;
  localparam int          MA_LO          = -32768;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  trip_scoreboard         sb = new();
  int unsigned            idle_cycles = 0;
  int unsigned            n_settings = 0;
  bit                     tx_steady = 1'b0;
  bit                     pump_on = 1'b1;
  logic [MS_W-1:0]        clock_ms = '0;

  pump_current_fault_trip i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_sample(bit pump, logic signed [MA_W-1:0] ma, logic [MS_W-1:0] ms);
    pcft_sample_t s;
    int unsigned  gap;
    s.pump_active = pump;
    s.current_ma  = ma;
    s.now_ms      = ms;
    if ($urandom_range(0, 31) == 0) tx_steady = 1'($urandom_range(0, 1));
    gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W-MS_W-MA_W-1){1'b0}}, ms, ma, pump};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  // input idle and every result back, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(bit sensor, bit check, bit below,
                              logic signed [MA_W-1:0] thr, logic [DUR_S_W-1:0] dur);
    logic [CFG_DATA_W-1:0] junk;
    int unsigned           k;
    // upper bits of the flag registers carry noise half of the time
    junk = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1) == 0) junk = '0;
    reg_write(CFG_SENSOR_PRESENT, {junk[CFG_DATA_W-1:1], sensor});
    reg_write(CFG_CHECK_ENABLED,  {junk[CFG_DATA_W-1:1], check});
    reg_write(CFG_BELOW_MODE,     {junk[CFG_DATA_W-1:1], below});
    reg_write(CFG_THRESHOLD_MA,   thr);
    reg_write(CFG_DURATION_S,     dur);
    // unused indexes must leave everything alone
    for (k = CFG_DURATION_S + 1; k < 2**CFG_IDX_W; k++) begin
      junk = CFG_DATA_W'($urandom);
      reg_write(k[CFG_IDX_W-1:0], junk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(output int unsigned counted);
    bit                     sensor;
    bit                     check;
    bit                     below;
    logic signed [MA_W-1:0] thr;
    logic signed [MA_W-1:0] ma;
    logic [DUR_S_W-1:0]     dur;
    logic [MS_W-1:0]        hold_ms;
    int unsigned            n;
    int unsigned            i;
    int unsigned            off;
    int                     v;
    sensor = ($urandom_range(0, 9) != 0);
    check  = ($urandom_range(0, 4) != 0);
    below  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0:       thr = MA_W'(MA_LO);
      1:       thr = MA_W'(MA_HI);
      default: thr = MA_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       dur = '0;
      1:       dur = '1;
      default: dur = DUR_S_W'($urandom_range(0, 5));
    endcase
    hold_ms = dur * MS_PER_S;
    n = sensor ? $urandom_range(30, 90) : $urandom_range(5, 15);
    settle();
    program_regs(sensor, check, below, thr, dur);
    // start some phases just short of the timestamp wrap
    if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, hold_ms);
    for (i = 0; i < n; i++) begin
      if (pump_on) pump_on = ($urandom_range(0, 15) != 0);
      else pump_on = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) == 0) begin
        ma = MA_W'($urandom);
      end else begin
        // mostly on the tripping side of the threshold
        off = $urandom_range(0, 72);
        v = below ? int'(thr) - int'(off) + 8 : int'(thr) + int'(off) - 8;
        if (v > MA_HI) v = MA_HI;
        if (v < MA_LO) v = MA_LO;
        ma = MA_W'(v);
      end
      case ($urandom_range(0, 15))
        0:       clock_ms = $urandom;
        1:       ;
        default: clock_ms += $urandom_range(0, hold_ms / 3 + 20);
      endcase
      send_sample(pump_on, ma, clock_ms);
    end
    counted = sensor ? n : 0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    bit          rx_steady;
    rx_steady = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = 1'($urandom_range(0, 1));
      stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, $time);
    end
  end

  initial begin : stimulus
    int unsigned done_random;
    int unsigned got;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: checking off, range still empty
    send_sample(1'b0, 16'sd1234, 32'd0);
    send_sample(1'b1, 16'sh7FFF, 32'd1);
    send_sample(1'b1, 16'sh8000, 32'd2);
    send_sample(1'b1, 16'sd0,    32'd3);
    send_sample(1'b0, 16'sd5,    32'd4);
    settle();

    // below zero with no hold time: second qualifying sample trips
    program_regs(1'b1, 1'b1, 1'b1, 16'sd0, 16'd0);
    send_sample(1'b1, -16'sd1, 32'd100);
    send_sample(1'b1, -16'sd5, 32'd100);
    send_sample(1'b1, -16'sd5, 32'd101);
    send_sample(1'b1, 16'sd3,  32'd102);
    send_sample(1'b1, -16'sd2, 32'd103);
    send_sample(1'b0, -16'sd2, 32'd104);
    send_sample(1'b1, -16'sd2, 32'd105);
    send_sample(1'b1, -16'sd2, 32'd106);
    settle();

    // above mode, timing across the wrap, equal current does not count
    program_regs(1'b1, 1'b1, 1'b0, 16'sd100, 16'd1);
    send_sample(1'b0, 16'sd0,    32'hFFFF_FE00);
    send_sample(1'b1, 16'sd101,  32'hFFFF_FE00);
    send_sample(1'b1, 16'sd200,  32'h0000_01E7);
    send_sample(1'b1, 16'sh7FFF, 32'h0000_01E8);
    send_sample(1'b1, 16'sd100,  32'h0000_1000);
    send_sample(1'b1, 16'sd150,  32'h0000_1000);
    settle();

    // with checking off the pending start survives
    program_regs(1'b1, 1'b0, 1'b0, 16'sd100, 16'd1);
    send_sample(1'b1, 16'sd50, 32'h0000_1100);
    settle();
    program_regs(1'b1, 1'b1, 1'b0, 16'sd100, 16'd1);
    send_sample(1'b1, 16'sd150, 32'h0000_13E8);
    settle();

    // sensor missing: state frozen
    program_regs(1'b0, 1'b1, 1'b0, 16'sd100, 16'd0);
    send_sample(1'b1, 16'sh8000, 32'd7);
    send_sample(1'b0, 16'sd999,  32'd8);
    settle();

    // longest hold time, one millisecond short and then exactly reached
    program_regs(1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'hFFFF);
    send_sample(1'b0, 16'sd0, 32'd0);
    send_sample(1'b1, 16'sd0, 32'd0);
    send_sample(1'b1, 16'sd0, 32'd65_534_999);
    send_sample(1'b1, 16'sd0, 32'd65_535_000);

    done_random = 0;
    while (done_random < RANDOM_SAMPLES) begin
      random_phase(got);
      done_random += got;
    end

    settle();
    $display("covered %0d samples over %0d register settings, %0d results compared",
             sb.n_samples, n_settings, sb.n_checked);
    $display("%0d trips predicted, %0d mismatches", sb.n_trips, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### pump_current_fault_trip.f
hdl/pcft_pkg.sv
hdl/pcft_cfg_regs.sv
hdl/pcft_eval.sv
hdl/pump_current_fault_trip.sv
sim/trip_check_pkg.sv
sim/tb.sv
